>>> src/tshu_pkg.sv
// ----------------------------------------------------------------------------
// tshu_pkg
// Shared types, codes, tables and helpers for the steering heading unit.
// ----------------------------------------------------------------------------
package tshu_pkg;

  typedef enum logic [2:0] {
    MODE_SEEK    = 3'd0,
    MODE_FLEE    = 3'd1,
    MODE_ARRIVE  = 3'd2,
    MODE_FACE    = 3'd3,
    MODE_PURSUIT = 3'd4,
    MODE_EVADE   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_MAX_SPEED = 3'd1,
    REG_MAX_TURN  = 3'd2,
    REG_ARRIVE_R  = 3'd3,
    REG_EVADE_R   = 3'd4,
    REG_STOP_DIST = 3'd5
  } reg_idx_t;

  // divider operand widths: |vel| * dist is 24 x 32 bits, divisor is max speed or 4 * radius
  localparam int NUM_W = 56;
  localparam int DEN_W = 26;

  localparam int ATAN_N = 24;
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // carried alongside the first distance root
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [15:0]        hd;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } sb1_t;

  // carried alongside the prediction / arrive divide
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [15:0]        hd;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [31:0]        d;
    logic               x_neg;
    logic               x_nz;
    logic               y_neg;
    logic               y_nz;
    logic               lt_r;
    logic               le_5r;
  } sb2_t;

  // carried alongside the second distance root
  typedef struct packed {
    logic [15:0]        hd;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic [23:0]        speed;
    logic               valid;
  } sb3_t;

  // carried alongside the CORDIC
  typedef struct packed {
    logic [15:0] hd;
    logic [23:0] speed;
    logic        valid;
    logic        stop;
  } sb4_t;

  // saturate a 33-bit two's complement value to 32 bits
  function automatic logic [31:0] sat32(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/tshu_isqrt.sv
// ----------------------------------------------------------------------------
// tshu_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module tshu_isqrt #(
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [63:0]     in_val,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output logic [31:0]     out_root,
  output logic [SB_W-1:0] out_sb
);

  localparam int STEPS = 32;

  logic            vld [0:STEPS];
  logic [63:0]     rem [0:STEPS];
  logic [63:0]     res [0:STEPS];
  logic [SB_W-1:0] sb  [0:STEPS];

  assign vld[0] = in_vld;
  assign rem[0] = in_val;
  assign res[0] = 64'd0;
  assign sb[0]  = in_sb;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * s);
    logic [63:0] trial;
    assign trial = res[s] + BITV;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      sb[s+1] <= sb[s];
      if (rem[s] >= trial) begin
        rem[s+1] <= rem[s] - trial;
        res[s+1] <= (res[s] >> 1) + BITV;
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= res[s] >> 1;
      end
    end
  end

  assign out_vld  = vld[STEPS];
  assign out_root = res[STEPS][31:0];
  assign out_sb   = sb[STEPS];

endmodule

>>> src/tshu_div.sv
// ----------------------------------------------------------------------------
// tshu_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tshu_div #(
  parameter int SB_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [tshu_pkg::NUM_W-1:0] in_num,
  input  logic [tshu_pkg::DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]           in_sb,
  output logic                      out_vld,
  output logic [tshu_pkg::NUM_W-1:0] out_quo,
  output logic [SB_W-1:0]           out_sb
);

  localparam int NW = tshu_pkg::NUM_W;
  localparam int DW = tshu_pkg::DEN_W;

  logic          vld [0:NW];
  logic [NW-1:0] num [0:NW];
  logic [NW-1:0] quo [0:NW];
  logic [DW-1:0] rem [0:NW];
  logic [DW-1:0] den [0:NW];
  logic [SB_W-1:0] sb [0:NW];

  assign vld[0] = in_vld;
  assign num[0] = in_num;
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign den[0] = in_den;
  assign sb[0]  = in_sb;

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem[s], num[s][NW-1]};
    assign ge    = trial >= {1'b0, den[s]};
    assign diff  = trial - {1'b0, den[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      sb[s+1]  <= sb[s];
      den[s+1] <= den[s];
      num[s+1] <= {num[s][NW-2:0], 1'b0};
      quo[s+1] <= {quo[s][NW-2:0], ge};
      rem[s+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign out_vld = vld[NW];
  assign out_quo = quo[NW];
  assign out_sb  = sb[NW];

endmodule

>>> src/tshu_cordic.sv
// ----------------------------------------------------------------------------
// tshu_cordic
// Pipelined CORDIC vectoring atan2, 32-bit binary angle rounded to 16 bits.
// ----------------------------------------------------------------------------
module tshu_cordic #(
  parameter int STAGES = 16,
  parameter int SB_W   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic [SB_W-1:0]    in_sb,
  output logic               out_vld,
  output logic [15:0]        out_angle,
  output logic [SB_W-1:0]    out_sb
);

  // headroom for the negated minimum and the CORDIC gain
  localparam int XW = 35;

  logic                 vld  [0:STAGES];
  logic                 zero [0:STAGES];
  logic signed [XW-1:0] xq   [0:STAGES];
  logic signed [XW-1:0] yq   [0:STAGES];
  logic [31:0]          zq   [0:STAGES];
  logic [SB_W-1:0]      sb   [0:STAGES];

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic [31:0]          z_rnd;

  assign x_ext = XW'(in_x);
  assign y_ext = XW'(in_y);

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sb[0]   <= in_sb;
    zero[0] <= (in_x == 32'sd0) && (in_y == 32'sd0);
    if (in_x < 32'sd0) begin
      xq[0] <= -x_ext;
      yq[0] <= -y_ext;
      zq[0] <= 32'h8000_0000;
    end else begin
      xq[0] <= x_ext;
      yq[0] <= y_ext;
      zq[0] <= 32'h0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      sb[i+1]   <= sb[i];
      zero[i+1] <= zero[i];
      if (yq[i] > 0) begin
        xq[i+1] <= xq[i] + (yq[i] >>> i);
        yq[i+1] <= yq[i] - (xq[i] >>> i);
        zq[i+1] <= zq[i] + tshu_pkg::ATAN_TAB[i];
      end else begin
        xq[i+1] <= xq[i] - (yq[i] >>> i);
        yq[i+1] <= yq[i] + (xq[i] >>> i);
        zq[i+1] <= zq[i] - tshu_pkg::ATAN_TAB[i];
      end
    end
  end

  assign z_rnd = zq[STAGES] + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_sb    <= sb[STAGES];
    out_angle <= zero[STAGES] ? 16'd0 : z_rnd[31:16];
  end

endmodule

>>> src/target_steering_heading_unit_core.sv
// ----------------------------------------------------------------------------
// target_steering_heading_unit_core
// Steering speed and turn rate for seek, flee, arrive, face, pursuit, evade.
// ----------------------------------------------------------------------------
// Pipeline: registered stages around two 32-stage square roots, a 56-stage
//   divider and the CORDIC, from start to done.
// Throughput: one item per cycle; busy stays low and results cannot stall.
// Reset: rst clears all pipeline valid bits and done, and loads the register defaults.
// ----------------------------------------------------------------------------
module target_steering_heading_unit_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic signed [31:0] agent_x,
  input  logic signed [31:0] agent_y,
  input  logic [15:0]        agent_heading,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [23:0] target_vel_x,
  input  logic signed [23:0] target_vel_y,
  output logic               done,
  output logic [23:0]        linear_speed,
  output logic signed [15:0] turn_rate,
  output logic               steer_valid
);

  localparam int NW = tshu_pkg::NUM_W;
  localparam int DW = tshu_pkg::DEN_W;

  // configuration
  logic [2:0]  behavior_mode;
  logic [23:0] max_linear_speed;
  logic [14:0] max_turn_rate;
  logic [23:0] arrive_radius;
  logic [23:0] evade_radius;
  logic [23:0] pursuit_stop_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      behavior_mode         <= tshu_pkg::MODE_SEEK;
      max_linear_speed      <= 24'd153600;
      max_turn_rate         <= 15'd32767;
      arrive_radius         <= 24'd25600;
      evade_radius          <= 24'd128000;
      pursuit_stop_distance <= 24'd5120;
    end else if (cfg_we) begin
      case (cfg_index)
        tshu_pkg::REG_MODE:      behavior_mode         <= cfg_data[2:0];
        tshu_pkg::REG_MAX_SPEED: max_linear_speed      <= cfg_data;
        tshu_pkg::REG_MAX_TURN:  max_turn_rate         <= cfg_data[14:0];
        tshu_pkg::REG_ARRIVE_R:  arrive_radius         <= cfg_data;
        tshu_pkg::REG_EVADE_R:   evade_radius          <= cfg_data;
        tshu_pkg::REG_STOP_DIST: pursuit_stop_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stages 0..3: capture, difference, squares, sum
  logic               s0_vld, s1_vld, s2_vld, s3_vld;
  logic signed [31:0] s0_ax, s0_ay, s0_tx, s0_ty;
  logic [15:0]        s0_hd;
  logic signed [23:0] s0_vx, s0_vy;
  tshu_pkg::sb1_t     s1_sb, s2_sb, s3_sb;
  logic signed [63:0] s2_sqx, s2_sqy;
  logic [63:0]        s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_ax <= agent_x;
    s0_ay <= agent_y;
    s0_hd <= agent_heading;
    s0_tx <= target_x;
    s0_ty <= target_y;
    s0_vx <= target_vel_x;
    s0_vy <= target_vel_y;

    s1_sb.ax <= s0_ax;
    s1_sb.ay <= s0_ay;
    s1_sb.tx <= s0_tx;
    s1_sb.ty <= s0_ty;
    s1_sb.hd <= s0_hd;
    s1_sb.vx <= s0_vx;
    s1_sb.vy <= s0_vy;
    s1_sb.dx <= tshu_pkg::sat32({s0_tx[31], s0_tx} - {s0_ax[31], s0_ax});
    s1_sb.dy <= tshu_pkg::sat32({s0_ty[31], s0_ty} - {s0_ay[31], s0_ay});

    s2_sb  <= s1_sb;
    s2_sqx <= s1_sb.dx * s1_sb.dx;
    s2_sqy <= s1_sb.dy * s1_sb.dy;

    s3_sb  <= s2_sb;
    s3_sum <= s2_sqx + s2_sqy;
  end

  // ---------------- distance to target
  logic           r1_vld;
  logic [31:0]    r1_d;
  tshu_pkg::sb1_t r1_sb;

  tshu_isqrt #(.SB_W($bits(tshu_pkg::sb1_t))) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s3_vld),
    .in_val   (s3_sum),
    .in_sb    (s3_sb),
    .out_vld  (r1_vld),
    .out_root (r1_d),
    .out_sb   (r1_sb)
  );

  // ---------------- stage 4: divide operands (prediction or arrive ramp)
  logic           is_arrive;
  logic [31:0]    d_minus_r;
  logic [26:0]    five_r;
  logic [23:0]    mag_vx, mag_vy;
  logic [23:0]    op_ax;
  logic [31:0]    op_bx;
  logic           s4_vld;
  logic [NW-1:0]  s4_num_x, s4_num_y;
  logic [DW-1:0]  s4_den;
  tshu_pkg::sb2_t s4_sb;

  always_comb begin
    is_arrive = behavior_mode == tshu_pkg::MODE_ARRIVE;
    d_minus_r = r1_d - {8'd0, arrive_radius};
    five_r    = ({3'd0, arrive_radius} << 2) + {3'd0, arrive_radius};
    mag_vx    = r1_sb.vx[23] ? (~r1_sb.vx + 24'd1) : r1_sb.vx;
    mag_vy    = r1_sb.vy[23] ? (~r1_sb.vy + 24'd1) : r1_sb.vy;
    op_ax     = is_arrive ? max_linear_speed : mag_vx;
    op_bx     = is_arrive ? d_minus_r : r1_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_num_x    <= op_ax * op_bx;
    s4_num_y    <= mag_vy * r1_d;
    s4_den      <= is_arrive ? {arrive_radius, 2'b00} : {2'b00, max_linear_speed};
    s4_sb.ax    <= r1_sb.ax;
    s4_sb.ay    <= r1_sb.ay;
    s4_sb.tx    <= r1_sb.tx;
    s4_sb.ty    <= r1_sb.ty;
    s4_sb.hd    <= r1_sb.hd;
    s4_sb.dx    <= r1_sb.dx;
    s4_sb.dy    <= r1_sb.dy;
    s4_sb.d     <= r1_d;
    s4_sb.x_neg <= r1_sb.vx[23];
    s4_sb.x_nz  <= (r1_sb.vx != 24'sd0) && (r1_d != 32'd0);
    s4_sb.y_neg <= r1_sb.vy[23];
    s4_sb.y_nz  <= (r1_sb.vy != 24'sd0) && (r1_d != 32'd0);
    s4_sb.lt_r  <= r1_d < {8'd0, arrive_radius};
    s4_sb.le_5r <= r1_d <= {5'd0, five_r};
  end

  // ---------------- dividers
  logic           q_vld;
  logic [NW-1:0]  quo_x, quo_y;
  tshu_pkg::sb2_t q_sb;

  tshu_div #(.SB_W($bits(tshu_pkg::sb2_t))) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s4_vld),
    .in_num  (s4_num_x),
    .in_den  (s4_den),
    .in_sb   (s4_sb),
    .out_vld (q_vld),
    .out_quo (quo_x),
    .out_sb  (q_sb)
  );

  tshu_div #(.SB_W(1)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s4_vld),
    .in_num  (s4_num_y),
    .in_den  (s4_den),
    .in_sb   (1'b0),
    .out_vld (),
    .out_quo (quo_y),
    .out_sb  ()
  );

  // signed, saturated offset from a quotient magnitude
  function automatic logic [31:0] off_calc(input logic [NW-1:0] q, input logic neg,
                                           input logic nz, input logic m_zero);
    logic [31:0] r;
    if (m_zero) begin
      r = !nz ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (neg) begin
      r = (q > NW'(33'h0_8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      r = (q > NW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  // ---------------- stages 6..10: offset, predicted point, aim vector and speed, squares, sum
  logic               s6_vld, s7_vld, s8_vld;
  logic signed [31:0] s6_offx, s6_offy;
  logic [23:0]        s6_arr_q;
  tshu_pkg::sb2_t     s6_sb, s7_sb;
  logic signed [31:0] s7_px, s7_py;
  logic [23:0]        s7_arr_q;
  tshu_pkg::sb3_t     s8_sb;
  logic signed [63:0] s9_sqx, s9_sqy;
  logic               s9_vld, s10_vld;
  tshu_pkg::sb3_t     s9_sb, s10_sb;
  logic [63:0]        s10_sum;
  logic signed [31:0] vec_x, vec_y;
  logic [23:0]        speed_pre;
  logic               valid_pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
    end else begin
      s6_vld  <= q_vld;
      s7_vld  <= s6_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
    end
  end

  always_comb begin
    vec_x     = s7_sb.dx;
    vec_y     = s7_sb.dy;
    speed_pre = 24'd0;
    valid_pre = 1'b1;
    case (behavior_mode)
      tshu_pkg::MODE_SEEK, tshu_pkg::MODE_FLEE: speed_pre = max_linear_speed;
      tshu_pkg::MODE_FACE: speed_pre = 24'd0;
      tshu_pkg::MODE_ARRIVE: begin
        if (s7_sb.lt_r) begin
          speed_pre = 24'd0;
        end else if (s7_sb.le_5r) begin
          // zero radius only reaches here at zero distance
          speed_pre = (arrive_radius == 24'd0) ? 24'd0 : s7_arr_q;
        end else begin
          speed_pre = max_linear_speed;
        end
      end
      tshu_pkg::MODE_PURSUIT: begin
        speed_pre = max_linear_speed;
        vec_x = tshu_pkg::sat32({s7_px[31], s7_px} - {s7_sb.ax[31], s7_sb.ax});
        vec_y = tshu_pkg::sat32({s7_py[31], s7_py} - {s7_sb.ay[31], s7_sb.ay});
      end
      tshu_pkg::MODE_EVADE: begin
        speed_pre = max_linear_speed;
        valid_pre = !(s7_sb.d > {8'd0, evade_radius});
        vec_x = tshu_pkg::sat32({s7_sb.ax[31], s7_sb.ax} - {s7_px[31], s7_px});
        vec_y = tshu_pkg::sat32({s7_sb.ay[31], s7_sb.ay} - {s7_py[31], s7_py});
      end
      default: begin
        speed_pre = 24'd0;
        valid_pre = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s6_sb    <= q_sb;
    s6_arr_q <= quo_x[23:0];
    s6_offx  <= off_calc(quo_x, q_sb.x_neg, q_sb.x_nz, max_linear_speed == 24'd0);
    s6_offy  <= off_calc(quo_y, q_sb.y_neg, q_sb.y_nz, max_linear_speed == 24'd0);

    s7_sb    <= s6_sb;
    s7_arr_q <= s6_arr_q;
    s7_px    <= tshu_pkg::sat32({s6_sb.tx[31], s6_sb.tx} + {s6_offx[31], s6_offx});
    s7_py    <= tshu_pkg::sat32({s6_sb.ty[31], s6_sb.ty} + {s6_offy[31], s6_offy});

    s8_sb.hd    <= s7_sb.hd;
    s8_sb.vec_x <= vec_x;
    s8_sb.vec_y <= vec_y;
    s8_sb.speed <= speed_pre;
    s8_sb.valid <= valid_pre;

    s9_sb  <= s8_sb;
    s9_sqx <= s8_sb.vec_x * s8_sb.vec_x;
    s9_sqy <= s8_sb.vec_y * s8_sb.vec_y;

    s10_sb  <= s9_sb;
    s10_sum <= s9_sqx + s9_sqy;
  end

  // ---------------- distance to the predicted point
  logic           r2_vld;
  logic [31:0]    r2_d;
  tshu_pkg::sb3_t r2_sb;

  tshu_isqrt #(.SB_W($bits(tshu_pkg::sb3_t))) u_dist_pred (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s10_vld),
    .in_val   (s10_sum),
    .in_sb    (s10_sb),
    .out_vld  (r2_vld),
    .out_root (r2_d),
    .out_sb   (r2_sb)
  );

  // ---------------- stage 11: pursuit stop check
  logic               s11_vld;
  logic signed [31:0] s11_x, s11_y;
  tshu_pkg::sb4_t     s11_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_vld <= 1'b0;
    end else begin
      s11_vld <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s11_x        <= r2_sb.vec_x;
    s11_y        <= r2_sb.vec_y;
    s11_sb.hd    <= r2_sb.hd;
    s11_sb.speed <= r2_sb.speed;
    s11_sb.valid <= r2_sb.valid;
    s11_sb.stop  <= (behavior_mode == tshu_pkg::MODE_PURSUIT) &&
                    (r2_d < {8'd0, pursuit_stop_distance});
  end

  // ---------------- aim angle
  logic           c_vld;
  logic [15:0]    c_angle;
  tshu_pkg::sb4_t c_sb;

  tshu_cordic #(.STAGES(CORDIC_STAGES), .SB_W($bits(tshu_pkg::sb4_t))) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (s11_vld),
    .in_x      (s11_x),
    .in_y      (s11_y),
    .in_sb     (s11_sb),
    .out_vld   (c_vld),
    .out_angle (c_angle),
    .out_sb    (c_sb)
  );

  // ---------------- final stage: wrap, clamp, mode fix-up
  logic signed [15:0] err;
  logic signed [15:0] lim;
  logic signed [15:0] turn_clamped;
  logic signed [15:0] turn_final;
  logic [23:0]        speed_final;

  always_comb begin
    err = c_angle - c_sb.hd;
    lim = {1'b0, max_turn_rate};
    if (err > lim) begin
      turn_clamped = lim;
    end else if (err < -lim) begin
      turn_clamped = -lim;
    end else begin
      turn_clamped = err;
    end
    speed_final = c_sb.speed;
    case (behavior_mode)
      tshu_pkg::MODE_SEEK, tshu_pkg::MODE_ARRIVE, tshu_pkg::MODE_FACE,
      tshu_pkg::MODE_EVADE: turn_final = turn_clamped;
      tshu_pkg::MODE_FLEE: turn_final = -turn_clamped;
      tshu_pkg::MODE_PURSUIT: begin
        // hold still once the predicted point is reached
        turn_final = c_sb.stop ? 16'sd0 : turn_clamped;
        if (c_sb.stop) begin
          speed_final = 24'd0;
        end
      end
      default: turn_final = 16'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    linear_speed <= speed_final;
    turn_rate    <= turn_final;
    steer_valid  <= c_sb.valid;
  end

endmodule

>>> test/target_steering_heading_unit_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// target_steering_heading_unit_core_tb
// Drives position, heading and target beats through every steering mode and
// register setting, predicts speed, turn rate and validity in the bench, and
// compares every done beat with the oldest prediction.
// ----------------------------------------------------------------------------
module target_steering_heading_unit_core_tb;

  localparam int LATENCY = 150;
  localparam longint LIMIT = 2_000_000;

  typedef struct {
    logic [23:0]        speed;
    logic signed [15:0] turn;
    logic               valid;
  } steer_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic signed [31:0] agent_x;
  logic signed [31:0] agent_y;
  logic [15:0]        agent_heading;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [23:0] target_vel_x;
  logic signed [23:0] target_vel_y;
  logic               done;
  logic [23:0]        linear_speed;
  logic signed [15:0] turn_rate;
  logic               steer_valid;

  // shadow registers
  logic [2:0]  sh_mode;
  logic [23:0] sh_max_speed;
  logic [14:0] sh_max_turn;
  logic [23:0] sh_arrive_r;
  logic [23:0] sh_evade_r;
  logic [23:0] sh_stop_dist;

  steer_t      pending_steer[$];
  int          mismatches;
  int          beats_sent;
  int          beats_checked;
  longint      cycle_count;
  bit          quiet_phase;

  target_steering_heading_unit_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .agent_x(agent_x), .agent_y(agent_y), .agent_heading(agent_heading),
    .target_x(target_x), .target_y(target_y),
    .target_vel_x(target_vel_x), .target_vel_y(target_vel_y),
    .done(done), .linear_speed(linear_speed), .turn_rate(turn_rate),
    .steer_valid(steer_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] range_of(longint dx, longint dy);
    logic [63:0] sx;
    logic [63:0] sy;
    sx = dx * dx;
    sy = dy * dy;
    return floor_root(sx + sy);
  endfunction

  function automatic logic [15:0] bearing(longint x, longint y);
    logic [31:0] z;
    longint nx;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shift_floor(y, i);
        y = y - shift_floor(x, i);
        z = z + tshu_pkg::ATAN_TAB[i];
      end else begin
        nx = x - shift_floor(y, i);
        y = y + shift_floor(x, i);
        z = z - tshu_pkg::ATAN_TAB[i];
      end
      x = nx;
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic int heading_error(longint dx, longint dy, logic [15:0] hd);
    logic [15:0] e;
    int err;
    int lim;
    e = bearing(dx, dy) - hd;
    err = $signed(e);
    lim = sh_max_turn;
    if (err > lim) err = lim;
    if (err < -lim) err = -lim;
    return err;
  endfunction

  function automatic longint lead_point(longint tpos, longint vel, logic [31:0] d);
    longint prod;
    longint off;
    prod = vel * longint'(d);
    if (sh_max_speed == 0) off = (prod > 0) ? 64'sd2147483647 :
                                 (prod < 0) ? -64'sd2147483648 : 0;
    else off = clamp32(prod / longint'(sh_max_speed));
    return clamp32(tpos + off);
  endfunction

  function automatic steer_t predict_steer(longint ax, longint ay, logic [15:0] hd,
                                           longint tx, longint ty, longint vx,
                                           longint vy);
    steer_t s;
    longint dx;
    longint dy;
    longint px;
    longint py;
    logic [31:0] d;
    logic [63:0] r;
    int turn;
    dx = clamp32(tx - ax);
    dy = clamp32(ty - ay);
    d = range_of(dx, dy);
    s.speed = 0;
    s.valid = 1'b1;
    turn = 0;
    case (sh_mode)
      tshu_pkg::MODE_SEEK, tshu_pkg::MODE_FLEE, tshu_pkg::MODE_FACE: begin
        turn = heading_error(dx, dy, hd);
        if (sh_mode == tshu_pkg::MODE_FLEE) turn = -turn;
        s.speed = (sh_mode == tshu_pkg::MODE_FACE) ? 24'd0 : sh_max_speed;
      end
      tshu_pkg::MODE_ARRIVE: begin
        r = sh_arrive_r;
        turn = heading_error(dx, dy, hd);
        if (64'(d) < r) s.speed = 0;
        else if (64'(d) <= 5 * r)
          s.speed = (r == 0) ? 24'd0 : 24'((64'(sh_max_speed) * (64'(d) - r)) / (4 * r));
        else s.speed = sh_max_speed;
      end
      tshu_pkg::MODE_PURSUIT, tshu_pkg::MODE_EVADE: begin
        px = lead_point(tx, vx, d);
        py = lead_point(ty, vy, d);
        if (sh_mode == tshu_pkg::MODE_PURSUIT) begin
          if (range_of(clamp32(px - ax), clamp32(py - ay)) < 32'(sh_stop_dist)) begin
            s.speed = 0;
            turn = 0;
          end else begin
            s.speed = sh_max_speed;
            turn = heading_error(clamp32(px - ax), clamp32(py - ay), hd);
          end
        end else begin
          s.valid = (d > 32'(sh_evade_r)) ? 1'b0 : 1'b1;
          s.speed = sh_max_speed;
          turn = heading_error(clamp32(ax - px), clamp32(ay - py), hd);
        end
      end
      default: begin
        s.valid = 1'b0;
      end
    endcase
    s.turn = 16'(turn);
    return s;
  endfunction

  task automatic tick();
    @(posedge clk);
  endtask

  // the following beat drops the write enable again
  task automatic write_reg(tshu_pkg::reg_idx_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tshu_pkg::REG_MODE:      sh_mode = val[2:0];
      tshu_pkg::REG_MAX_SPEED: sh_max_speed = val;
      tshu_pkg::REG_MAX_TURN:  sh_max_turn = val[14:0];
      tshu_pkg::REG_ARRIVE_R:  sh_arrive_r = val;
      tshu_pkg::REG_EVADE_R:   sh_evade_r = val;
      default:                 sh_stop_dist = val;
    endcase
    tick();
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_steer.size() != 0 && cycle_count < LIMIT) tick();
    repeat (LATENCY + 10) tick();
  endtask

  task automatic send_beat(logic [31:0] ax, logic [31:0] ay, logic [15:0] hd,
                           logic [31:0] tx, logic [31:0] ty, logic [23:0] vx,
                           logic [23:0] vy);
    cfg_we <= 1'b0;
    while (!quiet_phase && $urandom_range(99) < 12) begin
      start <= 1'b0;
      tick();
    end
    start <= 1'b1;
    agent_x <= ax;
    agent_y <= ay;
    agent_heading <= hd;
    target_x <= tx;
    target_y <= ty;
    target_vel_x <= vx;
    target_vel_y <= vy;
    pending_steer.push_back(predict_steer($signed(ax), $signed(ay), hd, $signed(tx),
                                          $signed(ty), $signed(vx), $signed(vy)));
    tick();
    while (busy) tick();
    beats_sent++;
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8000)) - 4000);
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  function automatic logic [23:0] rand_vel();
    if ($urandom_range(3) == 0) return $urandom;
    return 24'($signed($urandom_range(60000)) - 30000);
  endfunction

  task automatic random_beats(int n);
    logic [31:0] ax;
    logic [31:0] ay;
    for (int i = 0; i < n; i++) begin
      ax = rand_pos();
      ay = rand_pos();
      if ($urandom_range(1))
        send_beat(ax, ay, $urandom, ax + rand_pos() % 100000, ay + rand_pos() % 100000,
                  rand_vel(), rand_vel());
      else
        send_beat(ax, ay, $urandom, rand_pos(), rand_pos(), rand_vel(), rand_vel());
    end
  endtask

  task automatic test_directed_extremes();
    write_reg(tshu_pkg::REG_MODE, tshu_pkg::MODE_SEEK);
    send_beat(0, 0, 0, 0, 0, 0, 0);
    send_beat(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              24'h7F_FFFF, 24'h80_0000);
    send_beat(32'h7FFF_FFFF, 0, 16'h8000, 32'h8000_0000, 0, 24'h80_0000, 24'h7F_FFFF);
    // exact half-turn error
    send_beat(0, 0, 16'h0000, -32'sd1000, 0, 0, 0);
    send_beat(0, 0, 16'h4000, 0, 1000, 0, 0);
    send_beat(0, 0, 16'hC000, 0, -1000, 0, 0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
              24'hAA_AAAA, 24'h55_5555);
    for (int m = tshu_pkg::MODE_FLEE; m <= 7; m++) begin
      settle();
      write_reg(tshu_pkg::REG_MODE, 24'(m));
      send_beat(0, 0, 0, 30000, -20000, 1000, -500);
      send_beat(100, 100, 16'h2000, 100, 100, 0, 0);
      send_beat(0, 0, 16'h1234, 128000, 0, 24'h7F_FFFF, 24'h80_0000);
    end
  endtask

  task automatic test_arrive_ramp();
    settle();
    write_reg(tshu_pkg::REG_MODE, tshu_pkg::MODE_ARRIVE);
    write_reg(tshu_pkg::REG_ARRIVE_R, 24'd1000);
    for (int d = 990; d <= 5010; d += 502) send_beat(0, 0, 0, d, 0, 0, 0);
    send_beat(0, 0, 0, 1000, 0, 0, 0);
    send_beat(0, 0, 0, 5000, 0, 0, 0);
    send_beat(0, 0, 0, 5001, 0, 0, 0);
    settle();
    write_reg(tshu_pkg::REG_ARRIVE_R, 24'd0);
    send_beat(0, 0, 0, 0, 0, 0, 0);
    send_beat(0, 0, 0, 7, 0, 0, 0);
  endtask

  task automatic test_random_settings();
    logic [23:0] pick[3];
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      quiet_phase = (phase == 4);
      pick[0] = 0;
      pick[1] = 24'hFF_FFFF;
      pick[2] = $urandom_range(300000);
      write_reg(tshu_pkg::REG_MODE, 24'(phase % 8));
      write_reg(tshu_pkg::REG_MAX_SPEED, (phase == 2) ? 24'd0 : pick[$urandom_range(2)]);
      write_reg(tshu_pkg::REG_MAX_TURN, (phase == 3) ? 24'd0 : (phase == 5) ? 24'h7FFF
                                        : 24'($urandom_range(32767)));
      write_reg(tshu_pkg::REG_ARRIVE_R,
                (phase == 6) ? 24'hFF_FFFF : 24'($urandom_range(60000, 1)));
      write_reg(tshu_pkg::REG_EVADE_R, pick[$urandom_range(2)]);
      write_reg(tshu_pkg::REG_STOP_DIST, pick[$urandom_range(2)]);
      random_beats(80);
    end
    quiet_phase = 0;
  endtask

  // compare each done beat with the oldest prediction
  always @(posedge clk) begin
    steer_t want;
    if (!rst && done) begin
      if (pending_steer.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected done beat at cycle %0d", cycle_count);
      end else begin
        want = pending_steer.pop_front();
        beats_checked++;
        if (want.speed !== linear_speed || want.turn !== turn_rate ||
            want.valid !== steer_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: speed %0d/%0d turn %0d/%0d valid %0b/%0b (exp/act)",
                     want.speed, linear_speed, want.turn, turn_rate, want.valid,
                     steer_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    quiet_phase = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tshu_pkg::REG_MODE;
    cfg_data = 0;
    agent_x = 0;
    agent_y = 0;
    agent_heading = 0;
    target_x = 0;
    target_y = 0;
    target_vel_x = 0;
    target_vel_y = 0;
    sh_mode = tshu_pkg::MODE_SEEK;
    sh_max_speed = 24'd153600;
    sh_max_turn = 15'd32767;
    sh_arrive_r = 24'd25600;
    sh_evade_r = 24'd128000;
    sh_stop_dist = 24'd5120;
    repeat (10) tick();
    rst <= 1'b0;
    tick();
    test_directed_extremes();
    test_arrive_ramp();
    test_random_settings();
    settle();
    $display("Sent %0d beats across all six modes, the unused codes and register extremes;",
             beats_sent);
    $display("checked %0d results, %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && pending_steer.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/tshu_pkg.sv
src/tshu_isqrt.sv
src/tshu_div.sv
src/tshu_cordic.sv
src/target_steering_heading_unit_core.sv
test/target_steering_heading_unit_core_tb.sv
